@@ hw/rtl/ffra_pkg.sv @@
// ffra_pkg: types, sizes and codes for the first-fit region allocator.
// No dependencies.
package ffra_pkg;

    localparam int unsigned MEM_UNITS = 1024;
    localparam int unsigned FREE_N    = 16;
    localparam int unsigned BUSY_N    = 16;
    localparam int unsigned FIDX_W    = $clog2(FREE_N);
    localparam int unsigned FCNT_W    = $clog2(FREE_N + 1);
    localparam int unsigned BIDX_W    = $clog2(BUSY_N);
    localparam int unsigned BCNT_W    = $clog2(BUSY_N + 1);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  job_id;
        logic [10:0] request_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_start;
        logic [10:0] block_length;
    } rsp_t;

    typedef struct packed {
        logic [9:0]  start;
        logic [10:0] len;
    } free_ent_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [9:0]  start;
        logic [10:0] len;
    } busy_ent_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_BRD,
        S_BCHK,
        S_FRD,
        S_FCHK,
        S_MERGE,
        S_FDN_RD,
        S_FDN_WR,
        S_FUP_RD,
        S_FUP_WR,
        S_BDN_RD,
        S_BDN_WR,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/first_fit_region_allocator.sv @@
// Each request visits free or busy entries one at a time and may shift table entries
// one by one; a request can also be rejected at once. All table accesses go through
// the one read port and one write port of each table memory. One request at a time.
// Reset: asynchronous, on the state, counts and out_valid only; after reset, state
// S_INIT writes the initial free region (whole memory) while in_stall is high. Busy table holds no live blocks.
// Depends on ffra_pkg.
module first_fit_region_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ffra_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ffra_pkg::rsp_t out_data
);
    import ffra_pkg::*;

    free_ent_t free_mem [FREE_N];
    busy_ent_t busy_mem [BUSY_N];
    free_ent_t fq;
    busy_ent_t bq;

    logic              fwe, bwe;
    logic [FIDX_W-1:0] fwa, fra;
    logic [BIDX_W-1:0] bwa, bra;
    free_ent_t         fwd;
    busy_ent_t         bwd;

    state_t            state_reg, state_next;
    logic [FCNT_W-1:0] fcount_reg, fcount_next;
    logic [BCNT_W-1:0] bcount_reg, bcount_next;
    logic [FCNT_W-1:0] idx_reg, idx_next;
    logic [BCNT_W-1:0] bidx_reg, bidx_next;
    logic              hi_ok_reg, hi_ok_next;
    req_t              req_reg, req_next;
    logic [9:0]        st_reg, st_next;
    logic [10:0]       ln_reg, ln_next;
    free_ent_t         prev_reg, prev_next;
    free_ent_t         hq_reg, hq_next;
    rsp_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic [10:0]       lo_end, hi_end, newlen;
    logic              lo, hi;

    always_ff @(posedge clk)
    begin
        if (fwe)
        begin
            free_mem[fwa] <= fwd;
        end
        fq <= free_mem[fra];
        if (bwe)
        begin
            busy_mem[bwa] <= bwd;
        end
        bq <= busy_mem[bra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fcount_reg    <= FCNT_W'(1);
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcount_reg    <= fcount_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        bidx_reg  <= bidx_next;
        hi_ok_reg <= hi_ok_next;
        req_reg   <= req_next;
        st_reg    <= st_next;
        ln_reg    <= ln_next;
        prev_reg  <= prev_next;
        hq_reg    <= hq_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign lo_end = {1'b0, prev_reg.start} + prev_reg.len;
    assign hi_end = {1'b0, st_reg} + ln_reg;
    assign lo     = (idx_reg != '0) && (lo_end == {1'b0, st_reg});
    assign hi     = hi_ok_reg && (hi_end == {1'b0, hq_reg.start});
    assign newlen = fq.len - req_reg.request_length;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        fcount_next    = fcount_reg;
        bcount_next    = bcount_reg;
        idx_next       = idx_reg;
        bidx_next      = bidx_reg;
        hi_ok_next     = hi_ok_reg;
        req_next       = req_reg;
        st_next        = st_reg;
        ln_next        = ln_reg;
        prev_next      = prev_reg;
        hq_next        = hq_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        fwe = 1'b0;
        fwa = idx_reg[FIDX_W-1:0];
        fwd = fq;
        fra = idx_reg[FIDX_W-1:0];
        bwe = 1'b0;
        bwa = bidx_reg[BIDX_W-1:0];
        bwd = bq;
        bra = bidx_reg[BIDX_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                fwe = 1'b1;
                fwa = '0;
                fwd = '{start: '0, len: 11'(MEM_UNITS)};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_data;
                    idx_next  = '0;
                    bidx_next = '0;
                    res_next  = '{status: ST_OK, block_start: '0, block_length: '0};
                    if (in_data.action == ACT_ALLOC)
                    begin
                        if (in_data.request_length == '0 || fcount_reg == '0)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                    else if (bcount_reg == '0)
                    begin
                        res_next.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BRD;
                    end
                end
            end
            S_BRD:
            begin
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (bq.id == req_reg.job_id)
                begin
                    st_next    = bq.start;
                    ln_next    = bq.len;
                    idx_next   = '0;
                    hi_ok_next = 1'b0;
                    state_next = (fcount_reg == '0) ? S_MERGE : S_FRD;
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                    if (bidx_reg + 1'b1 == bcount_reg)
                    begin
                        res_next.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BRD;
                    end
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (req_reg.action == ACT_ALLOC)
                begin
                    if (fq.len >= req_reg.request_length)
                    begin
                        if (bcount_reg == BCNT_W'(BUSY_N))
                        begin
                            res_next.status = ST_TABLE_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            bwe = 1'b1;
                            bwa = bcount_reg[BIDX_W-1:0];
                            bwd = '{id: req_reg.job_id, start: fq.start,
                                    len: req_reg.request_length};
                            bcount_next = bcount_reg + 1'b1;
                            res_next = '{status: ST_OK, block_start: fq.start,
                                         block_length: req_reg.request_length};
                            if (newlen == '0)
                            begin
                                state_next = S_FDN_RD;
                            end
                            else
                            begin
                                fwe = 1'b1;
                                fwd.start = 10'({1'b0, fq.start} + req_reg.request_length);
                                fwd.len = newlen;
                                state_next = S_DONE;
                            end
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == fcount_reg)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                end
                else
                begin
                    if (fq.start <= st_reg)
                    begin
                        prev_next = fq;
                        idx_next  = idx_reg + 1'b1;
                        state_next = (idx_reg + 1'b1 == fcount_reg) ? S_MERGE : S_FRD;
                    end
                    else
                    begin
                        hq_next    = fq;
                        hi_ok_next = 1'b1;
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                res_next = '{status: ST_OK, block_start: st_reg, block_length: ln_reg};
                if (lo && hi)
                begin
                    fwe = 1'b1;
                    fwa = FIDX_W'(idx_reg - 1'b1);
                    fwd = '{start: prev_reg.start, len: prev_reg.len + ln_reg + hq_reg.len};
                    state_next = S_FDN_RD;
                end
                else if (lo)
                begin
                    fwe = 1'b1;
                    fwa = FIDX_W'(idx_reg - 1'b1);
                    fwd = '{start: prev_reg.start, len: prev_reg.len + ln_reg};
                    state_next = S_BDN_RD;
                end
                else if (hi)
                begin
                    fwe = 1'b1;
                    fwd = '{start: st_reg, len: hq_reg.len + ln_reg};
                    state_next = S_BDN_RD;
                end
                else if (fcount_reg == FCNT_W'(FREE_N))
                begin
                    res_next = '{status: ST_TABLE_FULL, block_start: '0, block_length: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = fcount_reg;
                    prev_next  = '{start: '0, len: 11'(idx_reg)};
                    state_next = S_FUP_RD;
                end
            end
            S_FDN_RD:
            begin
                if (idx_reg + 1'b1 < fcount_reg)
                begin
                    fra = FIDX_W'(idx_reg + 1'b1);
                    state_next = S_FDN_WR;
                end
                else
                begin
                    fcount_next = fcount_reg - 1'b1;
                    state_next = (req_reg.action == ACT_ALLOC) ? S_DONE : S_BDN_RD;
                end
            end
            S_FDN_WR:
            begin
                fwe = 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_FDN_RD;
            end
            S_FUP_RD:
            begin
                if (idx_reg > FCNT_W'(prev_reg.len))
                begin
                    fra = FIDX_W'(idx_reg - 1'b1);
                    state_next = S_FUP_WR;
                end
                else
                begin
                    fwe = 1'b1;
                    fwd = '{start: st_reg, len: ln_reg};
                    fcount_next = fcount_reg + 1'b1;
                    state_next = S_BDN_RD;
                end
            end
            S_FUP_WR:
            begin
                fwe = 1'b1;
                idx_next = idx_reg - 1'b1;
                state_next = S_FUP_RD;
            end
            S_BDN_RD:
            begin
                if (bidx_reg + 1'b1 < bcount_reg)
                begin
                    bra = BIDX_W'(bidx_reg + 1'b1);
                    state_next = S_BDN_WR;
                end
                else
                begin
                    bcount_next = bcount_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_BDN_WR:
            begin
                bwe = 1'b1;
                bidx_next = bidx_reg + 1'b1;
                state_next = S_BDN_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
